>>> rtl/core/block_byte_request_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// block byte request sequencer assertion macros
// shared assertion forms for the checker of the sequencer ports
// ----------------------------------------------------------------------------
`ifndef BLOCK_BYTE_REQUEST_SEQUENCER_TOP_DEFINES_SVH
`define BLOCK_BYTE_REQUEST_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define BBRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bbrs_pkg.sv
// ----------------------------------------------------------------------------
// bbrs_pkg
// types and constants of the block byte request sequencer
// ----------------------------------------------------------------------------
package bbrs_pkg;

    localparam int SECTOR_BYTES   = 512;
    localparam int SECTOR_SHIFT   = $clog2(SECTOR_BYTES);
    localparam int MAX_SECTORS    = 2048;
    localparam int MAX_XFER_BYTES = SECTOR_BYTES * MAX_SECTORS;

    localparam int OFFSET_W = 48;
    localparam int LEN_W    = 32;
    localparam int SECTOR_W = 39;
    localparam int COUNT_W  = 21;
    localparam int COFF_W   = 9;
    localparam int CLEN_W   = 10;

    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_LSB  = 2;
    localparam int REG_DEV_READY = 0;

    typedef enum logic [1:0] {
        REQ_READ       = 2'd0,
        REQ_WRITE      = 2'd1,
        REQ_FLUSH      = 2'd2,
        REQ_COMPLETION = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        KIND_CMD     = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_FAIL    = 2'd2,
        KIND_IGNORED = 2'd3
    } t_result_kind;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd_type;

    typedef enum logic [1:0] {
        COPY_NONE       = 2'd0,
        COPY_TO_CALLER  = 2'd1,
        COPY_TO_STAGING = 2'd2
    } t_copy_mode;

    typedef struct packed {
        t_req_type             req_type;
        logic [OFFSET_W-1:0]   start_addr;
        logic [LEN_W-1:0]      length;
        logic                  completion_ok;
    } t_req_item;

    typedef struct packed {
        t_result_kind          result_kind;
        t_cmd_type             cmd_type;
        logic [SECTOR_W-1:0]   sector;
        logic [COUNT_W-1:0]    byte_count;
        logic [LEN_W-1:0]      buffer_offset;
        logic                  use_staging;
        t_copy_mode            copy_mode;
        logic [COFF_W-1:0]     copy_offset;
        logic [CLEN_W-1:0]     copy_length;
    } t_res_item;

endpackage

>>> rtl/core/block_byte_request_sequencer_top.sv
// ----------------------------------------------------------------------------
// block_byte_request_sequencer_top
// splits byte read, write and flush requests into sector commands, one
// command per device completion
// ----------------------------------------------------------------------------
// channel  direction  signals                               payload
// in       sink       i_in_valid / o_in_ready               i_in_data  (t_req_item)
// out      source     o_out_valid / i_out_ready             o_out_data (t_res_item)
// cfg      apb        psel penable pwrite paddr pwdata ...  device_ready at 0x0
//
// each item is decoded against the request state in one pass; its result lands
// in the output register on the accepting edge, or in the skid register behind
// it while the output stalls; the skid register keeps input open for one item
// and o_in_ready drops only while the skid register is full
// synchronous active-low reset clears request state and both valid flags
// ----------------------------------------------------------------------------
module block_byte_request_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bbrs_pkg::t_req_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bbrs_pkg::t_res_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bbrs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bbrs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bbrs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef struct packed {
        bbrs_pkg::t_res_item                 res;
        logic [bbrs_pkg::COUNT_W-1:0]        last;
        logic                                rmw;
    } t_issue;

    localparam int CFG_IDX_W = bbrs_pkg::CFG_ADDR_W - bbrs_pkg::CFG_IDX_LSB;

    t_op                                 r_op, n_op;
    logic                                r_rmw, n_rmw;
    logic [bbrs_pkg::OFFSET_W-1:0]       r_cur, n_cur;
    logic [bbrs_pkg::LEN_W-1:0]          r_rem, n_rem;
    logic [bbrs_pkg::LEN_W-1:0]          r_prog, n_prog;
    logic [bbrs_pkg::COUNT_W-1:0]        r_last, n_last;
    logic                                r_dev_ready;
    logic                                r_out_valid, r_skid_valid;
    bbrs_pkg::t_res_item                 r_out_data, r_skid_data, n_res;

    logic                                in_fire, cfg_wr, cfg_hit;
    logic [bbrs_pkg::LEN_W-1:0]          step;
    logic [bbrs_pkg::OFFSET_W-1:0]       adv_cur;
    logic [bbrs_pkg::LEN_W-1:0]          adv_prog, adv_rem;
    t_issue                              iss_new, iss_adv;

    function automatic bbrs_pkg::t_res_item f_status(bbrs_pkg::t_result_kind kind);
        bbrs_pkg::t_res_item r;
        r             = '0;
        r.result_kind = kind;
        return r;
    endfunction

    function automatic t_issue f_issue(
        t_op                             op,
        logic [bbrs_pkg::OFFSET_W-1:0]   cur,
        logic [bbrs_pkg::LEN_W-1:0]      rem,
        logic [bbrs_pkg::LEN_W-1:0]      prog
    );
        t_issue                          o;
        logic [bbrs_pkg::COFF_W-1:0]     off;
        logic [bbrs_pkg::CLEN_W-1:0]     head;
        logic [bbrs_pkg::CLEN_W-1:0]     chunk;
        logic [bbrs_pkg::COUNT_W-1:0]    span;
        off   = cur[bbrs_pkg::SECTOR_SHIFT-1:0];
        head  = bbrs_pkg::CLEN_W'(bbrs_pkg::SECTOR_BYTES) - bbrs_pkg::CLEN_W'(off);
        chunk = (rem < bbrs_pkg::LEN_W'(head)) ? rem[bbrs_pkg::CLEN_W-1:0] : head;
        if (rem >= bbrs_pkg::LEN_W'(bbrs_pkg::MAX_XFER_BYTES)) begin
            span = bbrs_pkg::COUNT_W'(bbrs_pkg::MAX_XFER_BYTES);
        end else begin
            span = {rem[bbrs_pkg::COUNT_W-1:bbrs_pkg::SECTOR_SHIFT],
                    {bbrs_pkg::SECTOR_SHIFT{1'b0}}};
        end
        o                   = '0;
        o.res.result_kind   = bbrs_pkg::KIND_CMD;
        o.res.cmd_type      = bbrs_pkg::CMD_READ;
        o.res.sector        = cur[bbrs_pkg::OFFSET_W-1:bbrs_pkg::SECTOR_SHIFT];
        o.res.byte_count    = bbrs_pkg::COUNT_W'(bbrs_pkg::SECTOR_BYTES);
        o.res.buffer_offset = prog;
        o.res.use_staging   = 1'b1;
        o.res.copy_mode     = bbrs_pkg::COPY_NONE;
        o.last              = bbrs_pkg::COUNT_W'(chunk);
        o.rmw               = 1'b0;
        if (op == OP_READ) begin
            if (off == '0 && rem >= bbrs_pkg::LEN_W'(bbrs_pkg::SECTOR_BYTES)) begin
                o.res.byte_count  = span;
                o.res.use_staging = 1'b0;
                o.last            = span;
            end else begin
                o.res.copy_mode   = bbrs_pkg::COPY_TO_CALLER;
                o.res.copy_offset = off;
                o.res.copy_length = chunk;
            end
        end else if (off == '0 && chunk == bbrs_pkg::CLEN_W'(bbrs_pkg::SECTOR_BYTES)) begin
            o.res.cmd_type    = bbrs_pkg::CMD_WRITE;
            o.res.copy_mode   = bbrs_pkg::COPY_TO_STAGING;
            o.res.copy_length = chunk;
        end else begin
            o.rmw = 1'b1;
        end
        return o;
    endfunction

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[bbrs_pkg::CFG_ADDR_W-1:bbrs_pkg::CFG_IDX_LSB]
                      == CFG_IDX_W'(bbrs_pkg::REG_DEV_READY));
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? bbrs_pkg::CFG_DATA_W'(r_dev_ready) : '0;

    // advance past the finished command
    assign step     = (bbrs_pkg::LEN_W'(r_last) > r_rem) ? r_rem : bbrs_pkg::LEN_W'(r_last);
    assign adv_cur  = r_cur + bbrs_pkg::OFFSET_W'(step);
    assign adv_prog = r_prog + step;
    assign adv_rem  = r_rem - step;

    assign iss_new = f_issue((i_in_data.req_type == bbrs_pkg::REQ_READ) ? OP_READ : OP_WRITE,
                             i_in_data.start_addr, i_in_data.length, '0);
    assign iss_adv = f_issue(r_op, adv_cur, adv_rem, adv_prog);

    always_comb begin
        n_op   = r_op;
        n_rmw  = r_rmw;
        n_cur  = r_cur;
        n_rem  = r_rem;
        n_prog = r_prog;
        n_last = r_last;
        n_res  = f_status(bbrs_pkg::KIND_IGNORED);
        if (i_in_data.req_type != bbrs_pkg::REQ_COMPLETION) begin
            if (r_op != OP_IDLE) begin
                n_res = f_status(bbrs_pkg::KIND_IGNORED);
            end else if (!r_dev_ready) begin
                n_res = f_status(bbrs_pkg::KIND_FAIL);
            end else if (i_in_data.req_type == bbrs_pkg::REQ_FLUSH) begin
                n_op           = OP_FLUSH;
                n_rmw          = 1'b0;
                n_last         = '0;
                n_res          = f_status(bbrs_pkg::KIND_CMD);
                n_res.cmd_type = bbrs_pkg::CMD_FLUSH;
            end else if (i_in_data.length == '0) begin
                n_res = f_status(bbrs_pkg::KIND_DONE);
            end else begin
                n_op   = (i_in_data.req_type == bbrs_pkg::REQ_READ) ? OP_READ : OP_WRITE;
                n_cur  = i_in_data.start_addr;
                n_rem  = i_in_data.length;
                n_prog = '0;
                n_rmw  = iss_new.rmw;
                n_last = iss_new.last;
                n_res  = iss_new.res;
            end
        end else if (r_op == OP_IDLE) begin
            n_res = f_status(bbrs_pkg::KIND_IGNORED);
        end else if (!i_in_data.completion_ok) begin
            n_op  = OP_IDLE;
            n_rmw = 1'b0;
            n_res = f_status(bbrs_pkg::KIND_FAIL);
        end else if (r_op == OP_FLUSH) begin
            n_op  = OP_IDLE;
            n_rmw = 1'b0;
            n_res = f_status(bbrs_pkg::KIND_DONE);
        end else if (r_op == OP_WRITE && r_rmw) begin
            n_rmw               = 1'b0;
            n_res               = f_status(bbrs_pkg::KIND_CMD);
            n_res.cmd_type      = bbrs_pkg::CMD_WRITE;
            n_res.sector        = r_cur[bbrs_pkg::OFFSET_W-1:bbrs_pkg::SECTOR_SHIFT];
            n_res.byte_count    = bbrs_pkg::COUNT_W'(bbrs_pkg::SECTOR_BYTES);
            n_res.buffer_offset = r_prog;
            n_res.use_staging   = 1'b1;
            n_res.copy_mode     = bbrs_pkg::COPY_TO_STAGING;
            n_res.copy_offset   = r_cur[bbrs_pkg::SECTOR_SHIFT-1:0];
            n_res.copy_length   = r_last[bbrs_pkg::CLEN_W-1:0];
        end else begin
            n_cur  = adv_cur;
            n_prog = adv_prog;
            n_rem  = adv_rem;
            if (adv_rem == '0) begin
                n_op  = OP_IDLE;
                n_rmw = 1'b0;
                n_res = f_status(bbrs_pkg::KIND_DONE);
            end else begin
                n_rmw  = iss_adv.rmw;
                n_last = iss_adv.last;
                n_res  = iss_adv.res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op         <= OP_IDLE;
            r_rmw        <= 1'b0;
            r_cur        <= '0;
            r_rem        <= '0;
            r_prog       <= '0;
            r_last       <= '0;
            r_dev_ready  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_dev_ready <= pwdata[0];
            end
            if (in_fire) begin
                r_op   <= n_op;
                r_rmw  <= n_rmw;
                r_cur  <= n_cur;
                r_rem  <= n_rem;
                r_prog <= n_prog;
                r_last <= n_last;
            end
            if (in_fire) begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (!r_out_valid || i_out_ready) begin
                r_out_data <= n_res;
            end else begin
                r_skid_data <= n_res;
            end
        end else if (i_out_ready && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

endmodule

>>> rtl/core/bbrs_checker.sv
// ----------------------------------------------------------------------------
// bbrs_checker
// port-level checks of the block byte request sequencer
// ----------------------------------------------------------------------------
`include "block_byte_request_sequencer_top_defines.svh"

module bbrs_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input bbrs_pkg::t_res_item   o_out_data
);

    logic status_only, empty_copy, flush_cmd;
    logic chk_status, chk_copy, chk_flush, out_stall;
    logic status_clear, copy_clear, flush_clear;

    assign status_only = (o_out_data.result_kind != bbrs_pkg::KIND_CMD);
    assign empty_copy  = (o_out_data.copy_mode == bbrs_pkg::COPY_NONE);
    assign flush_cmd   = !status_only && (o_out_data.cmd_type == bbrs_pkg::CMD_FLUSH);

    assign chk_status = o_out_valid && status_only;
    assign chk_copy   = o_out_valid && !status_only && empty_copy;
    assign chk_flush  = o_out_valid && flush_cmd;
    assign out_stall  = o_out_valid && !i_out_ready;

    assign copy_clear   = (o_out_data.copy_offset == '0) && (o_out_data.copy_length == '0);
    assign flush_clear  = (o_out_data.sector == '0) && (o_out_data.byte_count == '0)
                          && !o_out_data.use_staging;
    assign status_clear = (o_out_data.cmd_type == bbrs_pkg::CMD_READ) && flush_clear
                          && (o_out_data.buffer_offset == '0) && empty_copy && copy_clear;

    `BBRS_ASSERT_NOW(a_status_fields_zero, chk_status, status_clear, "status item with fields")
    `BBRS_ASSERT_NOW(a_no_copy_fields, chk_copy, copy_clear, "copy fields without a copy")
    `BBRS_ASSERT_NOW(a_flush_shape, chk_flush, flush_clear, "flush command with data fields")
    `BBRS_ASSERT_NOW(a_stall_needs_output, !o_in_ready, o_out_valid, "input stall, no output")
    `BBRS_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data), "stall changed")

endmodule

bind block_byte_request_sequencer_top bbrs_checker u_bbrs_checker (.*);
